// ===== src/bpa_pkg.sv =====
// Package for the bsdiff patch apply core: item kinds, phases, fault codes,
// controller states and the command and status structs between the modules.
// No dependencies.
package bpa_pkg;

  localparam int OLD_DEPTH_DEF = 65536;
  localparam int WORD_W        = 64;
  localparam int SIGN_BIT      = 63;
  localparam int NEW_SIZE_W    = 32;
  localparam int OLD_SIZE_W    = 17;
  localparam int NEW_POS_W     = 33;
  localparam int LEN_W         = 32;
  localparam int ADDR_W        = 16;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NEW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_SIZE = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_CTRL  = 2'd1,
    KIND_DIFF  = 2'd2,
    KIND_EXTRA = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_CTRL  = 2'd0,
    PH_ADD   = 2'd1,
    PH_EXTRA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_KIND  = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHK1,
    ST_CHK2,
    ST_DIFF,
    ST_SEEK,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic cap;
    logic dec;
    logic chk1;
    logic chk2;
    logic diff;
    logic seek;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic dec_ctrl;
    logic dec_diff;
    logic dec_seek;
    logic chk1_ok;
    logic chk2_seek;
    logic diff_seek;
  } sts_t;

endpackage

// ===== src/bpa_if.sv =====
// Channel interfaces of the bsdiff patch apply core: input words, result
// words and configuration writes. Depends on bpa_pkg.
interface bpa_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [bpa_pkg::ADDR_W-1:0]        load_addr;
  logic [7:0]                        data_byte;
  logic [bpa_pkg::WORD_W-1:0]        add_word;
  logic [bpa_pkg::WORD_W-1:0]        extra_word;
  logic [bpa_pkg::WORD_W-1:0]        seek_word;

  modport source (output valid, kind, load_addr, data_byte, add_word, extra_word,
                  seek_word, input ready);
  modport sink (input valid, kind, load_addr, data_byte, add_word, extra_word,
                seek_word, output ready);
endinterface

interface bpa_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] new_byte;
  logic       done_res;
  logic [1:0] error;

  modport source (output valid, byte_valid, new_byte, done_res, error, input ready);
  modport sink (input valid, byte_valid, new_byte, done_res, error, output ready);
endinterface

interface bpa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bpa_pkg::CFG_IDX_W-1:0]       index;
  logic [bpa_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/bpa_ctrl.sv =====
// Controller state machine of the bsdiff patch apply core: sequences the
// steps of one word and owns the input and result handshakes. Depends on bpa_pkg.
module bpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bpa_pkg::sts_t  sts,
  output bpa_pkg::cmd_t  cmd
);
  import bpa_pkg::*;

  st_t  state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.dec = 1'b1;
        priority if (sts.dec_ctrl) state_nxt = ST_CHK1;
        else if (sts.dec_diff)     state_nxt = ST_DIFF;
        else if (sts.dec_seek)     state_nxt = ST_SEEK;
        else                       state_nxt = ST_FINISH;
      end
      ST_CHK1: begin
        cmd.chk1  = 1'b1;
        state_nxt = sts.chk1_ok ? ST_CHK2 : ST_FINISH;
      end
      ST_CHK2: begin
        cmd.chk2  = 1'b1;
        state_nxt = sts.chk2_seek ? ST_SEEK : ST_FINISH;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = sts.diff_seek ? ST_SEEK : ST_FINISH;
      end
      ST_SEEK: begin
        cmd.seek  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

endmodule

// ===== src/bpa_dp.sv =====
// Datapath of the bsdiff patch apply core: old file store, cursors, triple
// checks, byte rebuild and the result register. Depends on bpa_pkg.
module bpa_dp #(
  parameter int OLD_DEPTH = bpa_pkg::OLD_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bpa_pkg::cmd_t                     cmd,
  output bpa_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [1:0]                        in_kind,
  input  logic [bpa_pkg::ADDR_W-1:0]        in_load_addr,
  input  logic [7:0]                        in_data_byte,
  input  logic [bpa_pkg::WORD_W-1:0]        in_add_word,
  input  logic [bpa_pkg::WORD_W-1:0]        in_extra_word,
  input  logic [bpa_pkg::WORD_W-1:0]        in_seek_word,
  output logic                              out_byte_valid,
  output logic [7:0]                        out_new_byte,
  output logic                              out_done_res,
  output logic [1:0]                        out_error
);
  import bpa_pkg::*;

  localparam int AW = (OLD_DEPTH > 1) ? $clog2(OLD_DEPTH) : 1;
  localparam logic [WORD_W-1:0] MAG_MASK = {1'b0, {(WORD_W-1){1'b1}}};

  logic [7:0] mem [OLD_DEPTH];
  logic [7:0] rd_q;

  logic [NEW_SIZE_W-1:0] new_size_r;
  logic [OLD_SIZE_W-1:0] old_size_r;

  kind_t              kind_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [7:0]         data_r;
  logic [WORD_W-1:0]  aw_r, ew_r, sw_r;

  logic [NEW_POS_W-1:0] new_pos_r, new_pos_nxt;
  logic [WORD_W-1:0]    old_pos_r, old_pos_nxt;
  logic [LEN_W-1:0]     add_left_r, add_left_nxt;
  logic [LEN_W-1:0]     extra_left_r, extra_left_nxt;
  logic [WORD_W-1:0]    seek_r, seek_nxt;
  phase_t               phase_r, phase_nxt;
  fault_t               fault_r, fault_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic [7:0]           res_byte_r, res_byte_nxt;

  logic [WORD_W-1:0] a_r, e_r, rem_r, rem_a_r, seekval_r;
  logic              neg_r, a_gt_r, in_range_r;

  logic              ok, done_now, chk_fail, load_hit, mem_we, mem_re;
  logic [7:0]        old_byte;

  logic              ob_valid_r;
  logic [7:0]        ob_byte_r;
  logic              ob_done_r;
  logic [1:0]        ob_error_r;

  assign ok       = (fault_r == ERR_NONE);
  assign done_now = (phase_r == PH_CTRL) && (new_pos_r >= {1'b0, new_size_r});
  assign chk_fail = a_gt_r || (e_r > rem_a_r);
  assign load_hit = 32'(addr_r) < 32'(OLD_DEPTH);
  assign mem_we   = cmd.dec && ok && (kind_r == KIND_LOAD) && (phase_r == PH_CTRL)
                    && load_hit;
  assign mem_re   = cmd.dec && ok && (kind_r == KIND_DIFF) && (phase_r == PH_ADD);
  assign old_byte = in_range_r ? rd_q : 8'd0;

  assign sts.dec_ctrl  = ok && (kind_r == KIND_CTRL) && (phase_r == PH_CTRL) && !done_now;
  assign sts.dec_diff  = mem_re;
  assign sts.dec_seek  = ok && (kind_r == KIND_EXTRA) && (phase_r == PH_EXTRA)
                         && (extra_left_r == LEN_W'(1));
  assign sts.chk1_ok   = !neg_r;
  assign sts.chk2_seek = !chk_fail && (a_r[LEN_W-1:0] == '0) && (e_r[LEN_W-1:0] == '0);
  assign sts.diff_seek = (add_left_r == LEN_W'(1)) && (extra_left_r == '0);

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(addr_r)] <= data_r;
    if (mem_re) rd_q <= mem[AW'(old_pos_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_size_r <= '0;
      old_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NEW_SIZE: new_size_r <= cfg_wdata[NEW_SIZE_W-1:0];
        CFG_OLD_SIZE: old_size_r <= cfg_wdata[OLD_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r <= kind_t'(in_kind);
      addr_r <= in_load_addr;
      data_r <= in_data_byte;
      aw_r   <= in_add_word;
      ew_r   <= in_extra_word;
      sw_r   <= in_seek_word;
    end
    if (cmd.dec) begin
      a_r        <= aw_r & MAG_MASK;
      e_r        <= ew_r & MAG_MASK;
      neg_r      <= (aw_r[SIGN_BIT] && ((aw_r & MAG_MASK) != '0))
                    || (ew_r[SIGN_BIT] && ((ew_r & MAG_MASK) != '0));
      rem_r      <= WORD_W'(new_size_r) - WORD_W'(new_pos_r);
      seekval_r  <= sw_r[SIGN_BIT] ? ('0 - (sw_r & MAG_MASK)) : (sw_r & MAG_MASK);
      in_range_r <= (old_pos_r < WORD_W'(old_size_r)) && (old_pos_r < WORD_W'(OLD_DEPTH));
    end
    if (cmd.chk1) begin
      a_gt_r  <= a_r > rem_r;
      rem_a_r <= rem_r - a_r;
    end
    if (cmd.emit) begin
      ob_valid_r <= res_valid_r;
      ob_byte_r  <= res_byte_r;
      ob_done_r  <= done_now;
      ob_error_r <= fault_r;
    end
  end

  always_comb begin
    new_pos_nxt    = new_pos_r;
    old_pos_nxt    = old_pos_r;
    add_left_nxt   = add_left_r;
    extra_left_nxt = extra_left_r;
    seek_nxt       = seek_r;
    phase_nxt      = phase_r;
    fault_nxt      = fault_r;
    res_valid_nxt  = res_valid_r;
    res_byte_nxt   = res_byte_r;
    if (cmd.dec) begin
      res_valid_nxt = 1'b0;
      res_byte_nxt  = 8'd0;
      if (ok) begin
        unique case (kind_r)
          KIND_LOAD: begin
            if (phase_r != PH_CTRL) fault_nxt = ERR_KIND;
          end
          KIND_CTRL: begin
            if (phase_r != PH_CTRL || done_now) fault_nxt = ERR_KIND;
          end
          KIND_DIFF: begin
            if (phase_r != PH_ADD) fault_nxt = ERR_KIND;
          end
          KIND_EXTRA: begin
            if (phase_r != PH_EXTRA) begin
              fault_nxt = ERR_KIND;
            end else begin
              res_valid_nxt  = 1'b1;
              res_byte_nxt   = data_r;
              new_pos_nxt    = new_pos_r + NEW_POS_W'(1);
              extra_left_nxt = extra_left_r - LEN_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
    if (cmd.chk1 && neg_r) fault_nxt = ERR_RANGE;
    if (cmd.chk2) begin
      if (chk_fail) begin
        fault_nxt = ERR_RANGE;
      end else begin
        add_left_nxt   = a_r[LEN_W-1:0];
        extra_left_nxt = e_r[LEN_W-1:0];
        seek_nxt       = seekval_r;
        if (a_r[LEN_W-1:0] != '0)      phase_nxt = PH_ADD;
        else if (e_r[LEN_W-1:0] != '0) phase_nxt = PH_EXTRA;
      end
    end
    if (cmd.diff) begin
      res_valid_nxt = 1'b1;
      res_byte_nxt  = data_r + old_byte;
      old_pos_nxt   = old_pos_r + WORD_W'(1);
      new_pos_nxt   = new_pos_r + NEW_POS_W'(1);
      add_left_nxt  = add_left_r - LEN_W'(1);
      if (add_left_r == LEN_W'(1) && extra_left_r != '0) phase_nxt = PH_EXTRA;
    end
    if (cmd.seek) begin
      old_pos_nxt = old_pos_r + seek_r;
      seek_nxt    = '0;
      phase_nxt   = PH_CTRL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_pos_r    <= '0;
      old_pos_r    <= '0;
      add_left_r   <= '0;
      extra_left_r <= '0;
      seek_r       <= '0;
      phase_r      <= PH_CTRL;
      fault_r      <= ERR_NONE;
      res_valid_r  <= 1'b0;
      res_byte_r   <= 8'd0;
    end else begin
      new_pos_r    <= new_pos_nxt;
      old_pos_r    <= old_pos_nxt;
      add_left_r   <= add_left_nxt;
      extra_left_r <= extra_left_nxt;
      seek_r       <= seek_nxt;
      phase_r      <= phase_nxt;
      fault_r      <= fault_nxt;
      res_valid_r  <= res_valid_nxt;
      res_byte_r   <= res_byte_nxt;
    end
  end

  assign out_byte_valid = ob_valid_r;
  assign out_new_byte   = ob_byte_r;
  assign out_done_res   = ob_done_r;
  assign out_error      = ob_error_r;

endmodule

// ===== src/binary_patch_apply_core.sv =====
// Top level of the bsdiff patch apply core: joins controller and datapath to
// the three channel interfaces. Depends on bpa_pkg, bpa_if, bpa_ctrl, bpa_dp.
//
//   Channel  Dir  Word contents
//   in_ch    in   kind, load_addr, data_byte, add_word, extra_word, seek_word
//   out_ch   out  byte_valid, new_byte, done_res, error
//   cfg_ch   in   index (0 new_size, 1 old_size), data
//
// A load, extra byte or faulted word goes from decode to the final step; a diff
// byte adds the DIFF step because of the registered old store read, and a control
// word the CHK1 and CHK2 steps for its staged 64-bit range checks, or only CHK1
// when a negative length stops it after the first check; a step that ends a
// triple adds the SEEK step for the seek add. One word is in work at a time. A
// new word is taken while a result waits in the output register; out_ready low
// only holds the final step. Reset is synchronous; the old store is not cleared.
module binary_patch_apply_core #(
  parameter int OLD_DEPTH = bpa_pkg::OLD_DEPTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  bpa_in_if.sink  in_ch,
  bpa_out_if.source out_ch,
  bpa_cfg_if.sink cfg_ch
);
  import bpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dp #(
    .OLD_DEPTH (OLD_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_ch.valid),
    .cfg_idx        (cfg_ch.index),
    .cfg_wdata      (cfg_ch.data),
    .in_kind        (in_ch.kind),
    .in_load_addr   (in_ch.load_addr),
    .in_data_byte   (in_ch.data_byte),
    .in_add_word    (in_ch.add_word),
    .in_extra_word  (in_ch.extra_word),
    .in_seek_word   (in_ch.seek_word),
    .out_byte_valid (out_ch.byte_valid),
    .out_new_byte   (out_ch.new_byte),
    .out_done_res   (out_ch.done_res),
    .out_error      (out_ch.error)
  );

`ifndef NO_ASSERTIONS
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word taken while one is in work");

  a_fault_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error != ERR_NONE) |-> !out_ch.byte_valid)
    else $error("rebuilt byte reported with a fault");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> in_ch.ready)
    else $error("result presented while a word is still in work");
`endif

endmodule

// ===== dv/bpa_rebuild_checker.sv =====
// Scoreboard for the bsdiff patch apply core: watches the input, result and
// configuration channels, predicts every result word and compares it.
// Depends on bpa_pkg and the channel interfaces in bpa_if.
module bpa_rebuild_checker (
  input  logic      clk,
  input  logic      rst_n,
  bpa_in_if         in_mon,
  bpa_out_if        out_mon,
  bpa_cfg_if        cfg_mon,
  output int        fail_count,
  output int        pending,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] new_byte;
    logic       done_res;
    logic [1:0] error;
  } rebuilt_t;

  rebuilt_t    expected_q[$];
  logic [7:0]  old_mem [0:OLD_DEPTH_DEF-1];
  logic [63:0] wr_pos;
  logic [63:0] rd_cursor;
  logic [63:0] seek_pending;
  logic [31:0] diff_left;
  logic [31:0] copy_left;
  logic [31:0] size_new;
  logic [16:0] size_old;
  phase_t      stage;
  fault_t      fault_code;

  function automatic bit at_end();
    return stage == PH_CTRL && wr_pos >= {32'b0, size_new};
  endfunction

  function automatic logic [7:0] old_at(input logic [63:0] p);
    logic [63:0] lim;
    lim = (size_old > OLD_DEPTH_DEF) ? 64'(OLD_DEPTH_DEF) : {47'b0, size_old};
    return (p < lim) ? old_mem[p[15:0]] : 8'h00;
  endfunction

  function automatic void close_triple();
    rd_cursor = rd_cursor + seek_pending;
    seek_pending = '0;
    stage = PH_CTRL;
  endfunction

  function automatic void after_add();
    if (copy_left != 0) stage = PH_EXTRA;
    else close_triple();
  endfunction

  function automatic rebuilt_t rebuild_step(input kind_t k, input logic [15:0] addr,
                                            input logic [7:0] d, input logic [63:0] aw,
                                            input logic [63:0] ew, input logic [63:0] sw);
    rebuilt_t r;
    logic [63:0] a, e, rem, mag;
    r = '0;
    if (fault_code == ERR_NONE) begin
      case (k)
        KIND_LOAD: begin
          if (stage != PH_CTRL) fault_code = ERR_KIND;
          else old_mem[addr] = d;
        end
        KIND_CTRL: begin
          a = {1'b0, aw[62:0]};
          e = {1'b0, ew[62:0]};
          rem = {32'b0, size_new} - wr_pos;
          if (stage != PH_CTRL || at_end()) begin
            fault_code = ERR_KIND;
          end else if ((aw[63] && a != 0) || (ew[63] && e != 0)) begin
            fault_code = ERR_RANGE;
          end else if (a > rem || e > rem - a) begin
            fault_code = ERR_RANGE;
          end else begin
            diff_left = a[31:0];
            copy_left = e[31:0];
            mag = {1'b0, sw[62:0]};
            seek_pending = sw[63] ? (64'd0 - mag) : mag;
            if (diff_left != 0) stage = PH_ADD;
            else after_add();
          end
        end
        KIND_DIFF: begin
          if (stage != PH_ADD) begin
            fault_code = ERR_KIND;
          end else begin
            r.new_byte = d + old_at(rd_cursor);
            r.byte_valid = 1'b1;
            rd_cursor = rd_cursor + 1;
            wr_pos = wr_pos + 1;
            diff_left = diff_left - 1;
            if (diff_left == 0) after_add();
          end
        end
        default: begin
          if (stage != PH_EXTRA) begin
            fault_code = ERR_KIND;
          end else begin
            r.new_byte = d;
            r.byte_valid = 1'b1;
            wr_pos = wr_pos + 1;
            copy_left = copy_left - 1;
            if (copy_left == 0) close_triple();
          end
        end
      endcase
    end
    r.done_res = at_end();
    r.error = fault_code;
    return r;
  endfunction

  always @(posedge clk) begin
    rebuilt_t got, want;
    if (!rst_n) begin
      expected_q.delete();
      wr_pos = '0;
      rd_cursor = '0;
      seek_pending = '0;
      diff_left = '0;
      copy_left = '0;
      size_new = '0;
      size_old = '0;
      stage = PH_CTRL;
      fault_code = ERR_NONE;
      fail_count = 0;
      checked = 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{out_mon.byte_valid, out_mon.new_byte, out_mon.done_res, out_mon.error};
        checked++;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t ns: result word with nothing expected: v=%0b b=%02h d=%0b e=%0d",
                     $time, got.byte_valid, got.new_byte, got.done_res, got.error);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.byte_valid !== want.byte_valid || got.new_byte !== want.new_byte ||
              got.done_res !== want.done_res || got.error !== want.error) begin
            if (fail_count < 10)
              $display("%0t ns: expected v=%0b b=%02h d=%0b e=%0d, got v=%0b b=%02h d=%0b e=%0d",
                       $time, want.byte_valid, want.new_byte, want.done_res, want.error,
                       got.byte_valid, got.new_byte, got.done_res, got.error);
            fail_count++;
          end
        end
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        if (cfg_mon.index == CFG_NEW_SIZE) size_new = cfg_mon.data;
        else size_old = cfg_mon.data[16:0];
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        expected_q.push_back(rebuild_step(kind_t'(in_mon.kind), in_mon.load_addr,
                                          in_mon.data_byte, in_mon.add_word,
                                          in_mon.extra_word, in_mon.seek_word));
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/binary_patch_apply_core_test.sv =====
// Testbench top for the bsdiff patch apply core: drives patch words and
// register writes under several idle and stall mixes and gives the verdict.
// Depends on bpa_pkg, bpa_if, binary_patch_apply_core and bpa_rebuild_checker.
module binary_patch_apply_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  typedef enum int {
    BRK_NEG_LEN,
    BRK_PAST_END,
    BRK_LOAD_MID,
    BRK_CTRL_MID,
    BRK_DIFF_STRAY,
    BRK_EXTRA_STRAY,
    BRK_CTRL_DONE
  } breakage_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpa_in_if  in_ch();
  bpa_out_if out_ch();
  bpa_cfg_if cfg_ch();

  int fails;
  int pending;
  int checked;
  int send_idle = 0;
  int recv_stall = 0;
  int words_sent = 0;

  logic [63:0] cursor = '0;
  logic [63:0] made = '0;
  logic [31:0] nsize = '0;
  logic [16:0] osize = '0;
  bit          written [0:65535];
  breakage_t   brk;

  binary_patch_apply_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bpa_rebuild_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fails),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] seek_of(input logic [63:0] sw);
    logic [63:0] mag;
    mag = {1'b0, sw[62:0]};
    return sw[63] ? (64'd0 - mag) : mag;
  endfunction

  function automatic logic [63:0] seek_to(input logic [63:0] target, input logic [63:0] from);
    logic [63:0] delta, back;
    delta = target - from;
    back = from - target;
    return delta[63] ? {1'b1, back[62:0]} : delta;
  endfunction

  // A diff run may only read old bytes that were loaded or that lie outside the old file.
  function automatic bit cursor_safe(input logic [63:0] c, input int n);
    logic [63:0] p, lim;
    lim = {47'b0, osize};
    for (int i = 0; i < n; i++) begin
      p = c + 64'(i);
      if (p < lim && !written[p[15:0]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic set_mode(input int m);
    case (m)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 85; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 85; end
      default: begin send_idle = 6; recv_stall = 6; end
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.index = idx;
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == CFG_NEW_SIZE) nsize = value;
    else osize = value[16:0];
  endtask

  task automatic drive_word(input kind_t k, input logic [15:0] addr, input logic [7:0] d,
                            input logic [63:0] aw, input logic [63:0] ew,
                            input logic [63:0] sw);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.kind = k;
    in_ch.load_addr = addr;
    in_ch.data_byte = d;
    in_ch.add_word = aw;
    in_ch.extra_word = ew;
    in_ch.seek_word = sw;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_load(input logic [15:0] addr, input logic [7:0] d);
    drive_word(KIND_LOAD, addr, d, rnd64(), rnd64(), rnd64());
    written[addr] = 1'b1;
  endtask

  task automatic send_byte(input kind_t k);
    drive_word(k, 16'($urandom), pick_byte(), rnd64(), rnd64(), rnd64());
  endtask

  task automatic send_triple(input logic [63:0] aw, input logic [63:0] ew,
                             input logic [63:0] sw);
    int n_add, n_extra;
    n_add = int'(aw[62:0]);
    n_extra = int'(ew[62:0]);
    drive_word(KIND_CTRL, 16'($urandom), 8'($urandom), aw, ew, sw);
    for (int i = 0; i < n_add; i++) send_byte(KIND_DIFF);
    for (int i = 0; i < n_extra; i++) send_byte(KIND_EXTRA);
    cursor = cursor + 64'(n_add) + seek_of(sw);
    made = made + 64'(n_add + n_extra);
  endtask

  task automatic random_triple();
    logic [63:0] rem, target, aw, ew, sw;
    int a, e, pick;
    rem = {32'b0, nsize} - made;
    if (rem <= 20 && $urandom_range(0, 3) == 0) begin
      a = $urandom_range(0, int'(rem));
      e = int'(rem) - a;
    end else begin
      a = $urandom_range(0, 12);
      if (a > rem) a = int'(rem);
      e = $urandom_range(0, 8);
      if (e > rem - 64'(a)) e = int'(rem - 64'(a));
    end
    if (!cursor_safe(cursor, a)) a = 0;
    pick = $urandom_range(0, 7);
    case (pick)
      0: target = 64'd0 - 64'($urandom_range(1, 40));
      1: target = {47'b0, osize} + 64'($urandom_range(0, 1000));
      2: target = 64'hFFFE;
      default: target = 64'($urandom_range(0, 63));
    endcase
    sw = (pick == 3) ? rnd64() : seek_to(target, cursor + 64'(a));
    aw = (a == 0 && $urandom_range(0, 1) == 1) ? {1'b1, 63'd0} : 64'(a);
    ew = (e == 0 && $urandom_range(0, 1) == 1) ? {1'b1, 63'd0} : 64'(e);
    send_triple(aw, ew, sw);
  endtask

  initial begin
    int osize_plan [8];
    osize_plan = '{64, 0, 1, 65536, -1, 65536, 64, -1};
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.load_addr = '0;
    in_ch.data_byte = '0;
    in_ch.add_word = '0;
    in_ch.extra_word = '0;
    in_ch.seek_word = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_NEW_SIZE;
    cfg_ch.data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_NEW_SIZE, 32'd0);
    write_reg(CFG_OLD_SIZE, 32'd0);
    send_load(16'h0000, 8'h00);
    send_load(16'hFFFF, 8'hFF);
    send_load(16'h0001, 8'hFF);
    send_load(16'h0002, 8'h80);
    send_load(16'h0003, 8'h7F);
    wait_drained();
    write_reg(CFG_NEW_SIZE, 32'd14);
    write_reg(CFG_OLD_SIZE, 32'd4);
    send_triple(64'd3, 64'd1, {1'b1, 63'd5});
    send_triple({1'b1, 63'd0}, 64'd0, 64'd1);
    send_triple(64'd2, 64'd0, 64'd10);
    send_triple(64'd0, 64'd2, {1'b1, 63'd0});
    send_triple(64'd2, 64'd4, {1'b1, 63'd13});
    send_load(16'h0004, pick_byte());

    for (int ph = 0; ph < 8; ph++) begin
      int start;
      wait_drained();
      set_mode(ph % 4);
      write_reg(CFG_OLD_SIZE, (osize_plan[ph] < 0) ? $urandom_range(0, 65536) : osize_plan[ph]);
      write_reg(CFG_NEW_SIZE, (ph == 5) ? 32'hFFFF_FFFF : 32'(made) + $urandom_range(60, 200));
      start = words_sent;
      if (ph == 0) begin
        for (int i = 0; i < 64; i++) send_load(16'(i), pick_byte());
      end else begin
        repeat ($urandom_range(0, 12))
          send_load(($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 127)) : 16'($urandom),
                    pick_byte());
      end
      while (made < {32'b0, nsize} && words_sent - start < 140) random_triple();
      if (ph == 2) begin
        wait_drained();
        write_reg(CFG_NEW_SIZE, 32'd0);
        repeat (2) send_load(16'($urandom_range(0, 63)), pick_byte());
      end
    end

    wait_drained();
    set_mode($urandom_range(0, 3));
    brk = breakage_t'($urandom_range(0, 6));
    write_reg(CFG_NEW_SIZE, (brk == BRK_CTRL_DONE) ? 32'(made) : 32'(made) + 32'd40);
    case (brk)
      BRK_NEG_LEN:
        drive_word(KIND_CTRL, '0, '0, rnd64() | {1'b1, 62'd0, 1'b1}, 64'd1, rnd64());
      BRK_PAST_END:
        drive_word(KIND_CTRL, '0, '0, 64'd20, 64'd21, rnd64());
      BRK_LOAD_MID, BRK_CTRL_MID: begin
        drive_word(KIND_CTRL, '0, '0, 64'd0, 64'd3, 64'd0);
        send_byte(KIND_EXTRA);
        drive_word((brk == BRK_LOAD_MID) ? KIND_LOAD : KIND_CTRL, 16'($urandom), pick_byte(),
                   64'd1, 64'd1, rnd64());
      end
      BRK_DIFF_STRAY:  send_byte(KIND_DIFF);
      BRK_EXTRA_STRAY: send_byte(KIND_EXTRA);
      default:
        drive_word(KIND_CTRL, '0, '0, 64'd0, 64'd0, 64'd0);
    endcase
    repeat (20)
      drive_word(kind_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                 rnd64(), rnd64(), rnd64());

    for (int n = 0; n < 20000 && pending != 0; n++) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d input words under four idle and stall mixes; %0d result words checked.",
             words_sent, checked);
    $display("Rebuilt %0d bytes before ending on a %s breakage; %0d results still owed.",
             made, brk.name(), pending);
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
